// ===== rtl/emb_pkg.sv =====
// ----------------------------------------------------------------------------
// emb_pkg
// Shared codes and item types for the embedding lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

package emb_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ACCUM  = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ROW_RANGE = 2'd1,
        ST_SKIPPED   = 2'd2,
        ST_COL_RANGE = 2'd3
    } status_t;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_ROW_WIDTH   = 1'b1;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        req_t               req;
        status_t            status;
        logic [7:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
        logic [6:0]         width;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [31:0] data;
        logic [5:0]  element;
        logic        last;
        status_t     status;
    } rsp_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

endpackage

`default_nettype wire

// ===== rtl/emb_req_if.sv =====
// ----------------------------------------------------------------------------
// emb_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface emb_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         row_index;
    logic [5:0]         column;
    logic signed [31:0] value;
    logic               sequence_end;

    modport source (
        output valid, req_type, row_index, column, value, sequence_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_index, column, value, sequence_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/emb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// emb_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface emb_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [5:0]         element;
    logic               last;
    logic [1:0]         status;

    modport source (
        output valid, data, element, last, status,
        input  ready
    );

    modport sink (
        input  valid, data, element, last, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/embedding_lookup_and_grad_accumulate.sv =====
// ----------------------------------------------------------------------------
// embedding_lookup_and_grad_accumulate
// Embedding table engine: row lookup, gradient scatter-add, weight write
// and gradient read over two MAX_ROWS x MAX_WIDTH memories in Q16.16.
//
// Requests enter on the request channel, results leave on the response
// channel, both valid/ready. A lookup returns one result per element of the
// row, one a cycle while the result buffer has room; every other request
// returns a single result. With an empty engine the first result passes
// through the command queue, the read stage and the result buffer before it
// is offered. Element requests go at one a cycle while the result buffer has
// room; an accumulate holds the next command until its read-modify-write ends.
// A four-entry command queue sits between the classifying front end and
// the executing back end, and a four-entry result buffer lets requests keep
// flowing while the receiver stalls; once both fill, request ready drops.
// After reset the gradient memory is zeroed one entry a cycle, through all
// MAX_ROWS*MAX_WIDTH entries (16384 by default); no request is taken during
// that pass, while register writes on the APB port are taken as usual.
// rows_in_use sits at byte address 0 and row_width at byte address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module embedding_lookup_and_grad_accumulate
    import emb_pkg::*;
#(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    emb_req_if.sink     request,
    emb_rsp_if.source   response,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] rows_reg;
    logic [6:0] width_reg;
    logic       cfg_we;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic       clear_done;
    cmd_t       push_cmd;
    cmd_t       q_head;

    // Register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_ROWS_IN_USE: prdata = 32'(rows_reg);
            REG_ROW_WIDTH:   prdata = 32'(width_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 9'd256;
            width_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_ROWS_IN_USE)
            begin
                rows_reg <= pwdata[8:0];
            end
            else
            begin
                width_reg <= pwdata[6:0];
            end
        end
    end

    emb_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (request),
        .rows_in_use (rows_reg),
        .row_width   (width_reg),
        .enable      (clear_done),
        .q_full      (q_full),
        .push        (q_push),
        .push_cmd    (push_cmd)
    );

    emb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    emb_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .rsp        (response)
    );

endmodule

`default_nettype wire

// ===== rtl/emb_front.sv =====
// ----------------------------------------------------------------------------
// emb_front
// Accepts request items, range-checks them, tracks the abort state and
// pushes classified commands into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module emb_front
    import emb_pkg::*;
#(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_WIDTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    emb_req_if.sink    req,
    input  logic [8:0] rows_in_use,
    input  logic [6:0] row_width,
    input  logic       enable,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic       abort_reg;
    logic       abort_next;
    logic [6:0] w_eff;
    logic       row_ok;
    logic       col_ok;

    // Clip the configured row width to what the table holds; a width of zero counts as one
    function automatic logic [6:0] eff_width(input logic [6:0] rw);
        logic [6:0] w;
        w = rw;
        if (32'(w) > MAX_WIDTH)
        begin
            w = 7'(MAX_WIDTH);
        end
        if (w > 7'd64)
        begin
            w = 7'd64;
        end
        if (w == 7'd0)
        begin
            w = 7'd1;
        end
        return w;
    endfunction

    assign w_eff  = eff_width(row_width);
    assign row_ok = (9'(req.row_index) < rows_in_use) && (32'(req.row_index) < MAX_ROWS);
    assign col_ok = 7'(req.column) < w_eff;

    // Take an item only when the queue has room and the store is cleared
    assign req.ready = enable && !q_full;
    assign push      = req.valid && req.ready;

    // Classify the item
    always_comb
    begin
        abort_next      = abort_reg;
        push_cmd.req    = req_t'(req.req_type);
        push_cmd.row    = req.row_index;
        push_cmd.col    = req.column;
        push_cmd.value  = req.value;
        push_cmd.width  = w_eff;
        push_cmd.status = ST_OK;
        if (abort_reg)
        begin
            push_cmd.status = ST_SKIPPED;
        end
        else if (!row_ok)
        begin
            push_cmd.status = ST_ROW_RANGE;
            abort_next      = 1'b1;
        end
        else if (req_t'(req.req_type) != REQ_LOOKUP && !col_ok)
        begin
            push_cmd.status = ST_COL_RANGE;
        end
        if (req.sequence_end)
        begin
            abort_next = 1'b0;
        end
    end

    // Hold the abort state across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_reg <= 1'b0;
        end
        else if (push)
        begin
            abort_reg <= abort_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/emb_queue.sv =====
// ----------------------------------------------------------------------------
// emb_queue
// Short command queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module emb_queue
    import emb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/emb_back.sv =====
// ----------------------------------------------------------------------------
// emb_back
// Executes queued commands on the weight and gradient memories, streams
// lookups one element a cycle while output space allows, buffers results.
// ----------------------------------------------------------------------------
`default_nettype none

module emb_back
    import emb_pkg::*;
#(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      clear_done,
    emb_rsp_if.source rsp
);

    localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1;
    localparam int OPW   = $clog2(OUT_DEPTH);
    localparam int OCW   = $clog2(OUT_DEPTH + 2);

    localparam logic signed [SW-1:0] VMAX = {{(SW - VALUE_BITS + 1){1'b0}},
                                             {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;
    localparam logic signed [SW-1:0] OMAX = {{(SW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] OMIN = ~OMAX;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_WEIGHT = 2'd1,
        SRC_GRAD   = 2'd2
    } src_t;

    // Sequencer state
    state_t        state_reg,       state_next;
    logic [AW-1:0] clr_addr_reg,    clr_addr_next;
    logic [AW-1:0] look_base_reg,   look_base_next;
    logic [6:0]    look_width_reg,  look_width_next;
    logic [5:0]    elem_reg,        elem_next;

    // Read stage
    logic                   p1_valid_reg,  p1_valid_next;
    src_t                   p1_src_reg,    p1_src_next;
    logic                   p1_acc_reg,    p1_acc_next;
    logic [5:0]             p1_elem_reg,   p1_elem_next;
    logic                   p1_last_reg,   p1_last_next;
    status_t                p1_status_reg, p1_status_next;
    logic signed [31:0]     p1_value_reg,  p1_value_next;
    logic [AW-1:0]          p1_addr_reg,   p1_addr_next;

    // Memories
    logic signed [VALUE_BITS-1:0] weight_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] grad_mem   [DEPTH];
    logic signed [VALUE_BITS-1:0] w_rdata_reg;
    logic signed [VALUE_BITS-1:0] g_rdata_reg;
    logic                         w_re, w_we, g_re, g_we;
    logic [AW-1:0]                w_raddr, g_raddr, g_waddr;
    logic signed [VALUE_BITS-1:0] w_wdata, g_wdata, g_sum;

    // Output buffer
    rsp_t           oslot_reg [OUT_DEPTH];
    logic [OPW-1:0] o_wr_ptr_reg;
    logic [OPW-1:0] o_rd_ptr_reg;
    logic [OCW-1:0] o_count_reg;
    logic [OCW-1:0] o_count_next;
    logic           o_pop;
    rsp_t           res;

    logic [AW-1:0]  head_base;
    logic [AW-1:0]  head_addr;
    logic           credit_ok;
    logic           hazard;

    function automatic logic signed [VALUE_BITS-1:0] clamp_store(
        input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        y = x;
        if (x > VMAX)
        begin
            y = VMAX;
        end
        else if (x < VMIN)
        begin
            y = VMIN;
        end
        return VALUE_BITS'(y);
    endfunction

    function automatic logic [31:0] clamp_out(input logic signed [VALUE_BITS-1:0] v);
        logic signed [SW-1:0] x;
        x = SW'(v);
        if (x > OMAX)
        begin
            x = OMAX;
        end
        else if (x < OMIN)
        begin
            x = OMIN;
        end
        return 32'(x);
    endfunction

    assign head_base  = AW'(32'(q_head.row) * 32'(MAX_WIDTH));
    assign head_addr  = head_base + AW'(q_head.col);
    assign credit_ok  = (o_count_reg + OCW'(p1_valid_reg)) < OCW'(OUT_DEPTH);
    assign hazard     = p1_valid_reg && p1_acc_reg;
    assign clear_done = state_reg != S_CLEAR;
    assign w_wdata    = clamp_store(SW'($signed(q_head.value)));

    // Issue commands and lookup elements
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        look_base_next  = look_base_reg;
        look_width_next = look_width_reg;
        elem_next       = elem_reg;
        q_pop           = 1'b0;
        w_re            = 1'b0;
        w_we            = 1'b0;
        g_re            = 1'b0;
        w_raddr         = head_addr;
        g_raddr         = head_addr;
        p1_valid_next   = 1'b0;
        p1_src_next     = SRC_NONE;
        p1_acc_next     = 1'b0;
        p1_elem_next    = q_head.col;
        p1_last_next    = 1'b1;
        p1_status_next  = q_head.status;
        p1_value_next   = q_head.value;
        p1_addr_next    = head_addr;

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty && credit_ok && !hazard)
                begin
                    q_pop         = 1'b1;
                    p1_valid_next = 1'b1;
                    if (q_head.status != ST_OK)
                    begin
                        p1_elem_next = '0;
                    end
                    else
                    begin
                        case (q_head.req)
                            REQ_LOOKUP:
                            begin
                                w_re            = 1'b1;
                                w_raddr         = head_base;
                                p1_src_next     = SRC_WEIGHT;
                                p1_elem_next    = '0;
                                p1_last_next    = q_head.width == 7'd1;
                                look_base_next  = head_base;
                                look_width_next = q_head.width;
                                elem_next       = 6'd1;
                                if (q_head.width != 7'd1)
                                begin
                                    state_next = S_LOOKUP;
                                end
                            end
                            REQ_ACCUM:
                            begin
                                g_re        = 1'b1;
                                p1_acc_next = 1'b1;
                            end
                            REQ_WRITE:
                            begin
                                w_we = 1'b1;
                            end
                            REQ_READ:
                            begin
                                g_re        = 1'b1;
                                p1_src_next = SRC_GRAD;
                            end
                            default:
                            begin
                                p1_src_next = SRC_NONE;
                            end
                        endcase
                    end
                end
            end
            S_LOOKUP:
            begin
                if (credit_ok)
                begin
                    w_re           = 1'b1;
                    w_raddr        = look_base_reg + AW'(elem_reg);
                    p1_valid_next  = 1'b1;
                    p1_src_next    = SRC_WEIGHT;
                    p1_elem_next   = elem_reg;
                    p1_status_next = ST_OK;
                    p1_last_next   = (7'(elem_reg) + 7'd1) == look_width_reg;
                    elem_next      = elem_reg + 6'd1;
                    if (p1_last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Finish the accumulate and form the result
    assign g_sum = clamp_store(SW'(g_rdata_reg) + SW'(p1_value_reg));

    always_comb
    begin
        res.element = p1_elem_reg;
        res.last    = p1_last_reg;
        res.status  = p1_status_reg;
        case (p1_src_reg)
            SRC_WEIGHT: res.data = clamp_out(w_rdata_reg);
            SRC_GRAD:   res.data = clamp_out(g_rdata_reg);
            default:    res.data = '0;
        endcase
    end

    // Gradient write: clearing pass, then accumulate write-back
    assign g_we    = (state_reg == S_CLEAR) || (p1_valid_reg && p1_acc_reg);
    assign g_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : p1_addr_reg;
    assign g_wdata = (state_reg == S_CLEAR) ? '0 : g_sum;

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[head_addr] <= w_wdata;
        end
        if (w_re)
        begin
            w_rdata_reg <= weight_mem[w_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            grad_mem[g_waddr] <= g_wdata;
        end
        if (g_re)
        begin
            g_rdata_reg <= grad_mem[g_raddr];
        end
    end

    // Output buffer
    assign o_pop        = rsp.valid && rsp.ready;
    assign rsp.valid    = o_count_reg != '0;
    assign rsp.data     = oslot_reg[o_rd_ptr_reg].data;
    assign rsp.element  = oslot_reg[o_rd_ptr_reg].element;
    assign rsp.last     = oslot_reg[o_rd_ptr_reg].last;
    assign rsp.status   = oslot_reg[o_rd_ptr_reg].status;

    always_comb
    begin
        o_count_next = o_count_reg;
        if (p1_valid_reg && !o_pop)
        begin
            o_count_next = o_count_reg + OCW'(1);
        end
        else if (o_pop && !p1_valid_reg)
        begin
            o_count_next = o_count_reg - OCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            oslot_reg[o_wr_ptr_reg] <= res;
        end
    end

    // Read-stage payload
    always_ff @(posedge clk)
    begin
        p1_src_reg     <= p1_src_next;
        p1_acc_reg     <= p1_acc_next;
        p1_elem_reg    <= p1_elem_next;
        p1_last_reg    <= p1_last_next;
        p1_status_reg  <= p1_status_next;
        p1_value_reg   <= p1_value_next;
        p1_addr_reg    <= p1_addr_next;
        look_base_reg  <= look_base_next;
        look_width_reg <= look_width_next;
        elem_reg       <= elem_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            o_count_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            p1_valid_reg <= p1_valid_next;
            o_count_reg  <= o_count_next;
            if (p1_valid_reg)
            begin
                o_wr_ptr_reg <= o_wr_ptr_reg + OPW'(1);
            end
            if (o_pop)
            begin
                o_rd_ptr_reg <= o_rd_ptr_reg + OPW'(1);
            end
        end
    end

endmodule

`default_nettype wire
